### rtl/adl32_pkg.sv
// ----------------------------------------------------------------------------
// adl32_pkg
// Shared types and constants for the Adler-32 checksum unit.
// ----------------------------------------------------------------------------
package adl32_pkg;

  localparam int unsigned Lanes     = 4;
  localparam int unsigned CntW      = 3;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned SumW      = 16;
  localparam logic [16:0] AdlMod    = 17'd65521;
  localparam logic [31:0] SeedReset = 32'd1;

  // What one lane hands to the merge stage
  typedef struct packed {
    logic [ByteW-1:0] byte_val;   // byte, zero when the lane is unused
    logic [ByteW+1:0] weighted;   // byte times its high-sum weight
  } adl32_lane_t;

  typedef logic [ByteW-1:0] adl32_byte_t;

endpackage

### rtl/adler32_checksum_unit.sv
// ----------------------------------------------------------------------------
// adler32_checksum_unit
// Running Adler-32 checksum over a stream of up to four bytes per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries start_req, byte_count and four
//   byte lanes. byte_count bytes are taken from lane 0 upwards; counts above
//   four count as four, a count of zero adds nothing.
//   start_req loads both sums from the seed register before the bytes go in.
//   Every accepted item gives one result item on out_valid/out_stall: the
//   running checksum, high sum in bits 31..16, low sum in bits 15..0.
//   Each result is registered, into the skid register if the output register
//   still holds one. Throughput is one item per cycle while in_stall is low;
//   the four lanes and the merge adder are combinational. A two-deep output
//   (output register plus skid register) keeps in_stall a registered signal:
//   it rises only once both hold a result that the receiver has not taken, so
//   a stalled receiver costs no item. The user must write the seed through
//   seed_wr_en/seed_wr_data only while the unit is idle; nothing checks it.
//   Reset: seed 1, low sum 1, high sum 0, output side empty.
// ----------------------------------------------------------------------------
module adler32_checksum_unit (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        seed_wr_en,
  input  logic [31:0] seed_wr_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        start_req,
  input  logic [2:0]  byte_count,
  input  logic [7:0]  data_byte0,
  input  logic [7:0]  data_byte1,
  input  logic [7:0]  data_byte2,
  input  logic [7:0]  data_byte3,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] checksum
);
  import adl32_pkg::*;

  logic [31:0]     seed;
  logic [SumW-1:0] low_sum;
  logic [SumW-1:0] high_sum;
  logic [SumW-1:0] low_next;
  logic [SumW-1:0] high_next;
  logic [SumW-1:0] low_base;
  logic [SumW-1:0] high_base;
  logic [CntW-1:0] n_bytes;

  adl32_byte_t     lane_data [Lanes];
  adl32_lane_t     lane_res  [Lanes];

  logic            skid_full;
  logic [31:0]     skid_data;
  logic            accept;
  logic            out_fire;

  assign accept   = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign in_stall = skid_full;

  // Seed register
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SeedReset;
    end else if (seed_wr_en) begin
      seed <= seed_wr_data;
    end
  end

  // Start of message replaces the running sums by the seed halves
  assign low_base  = start_req ? seed[15:0]  : low_sum;
  assign high_base = start_req ? seed[31:16] : high_sum;
  assign n_bytes   = (byte_count > 3'(Lanes)) ? 3'(Lanes) : byte_count;

  assign lane_data[0] = data_byte0;
  assign lane_data[1] = data_byte1;
  assign lane_data[2] = data_byte2;
  assign lane_data[3] = data_byte3;

  for (genvar g = 0; g < Lanes; g++) begin : g_lane
    adl32_lane #(
      .LaneIdx (3'(g))
    ) u_lane (
      .n_bytes (n_bytes),
      .data    (lane_data[g]),
      .lane    (lane_res[g])
    );
  end

  adl32_merge u_merge (
    .lanes    (lane_res),
    .n_bytes  (n_bytes),
    .low_in   (low_base),
    .high_in  (high_base),
    .low_out  (low_next),
    .high_out (high_next)
  );

  // Running sums
  always_ff @(posedge clk) begin
    if (rst) begin
      low_sum  <= 16'd1;
      high_sum <= 16'd0;
    end else if (accept) begin
      low_sum  <= low_next;
      high_sum <= high_next;
    end
  end

  // Output register with skid behind it; order is kept by always
  // refilling the output register from the skid first
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (out_fire) begin
      if (skid_full) begin
        skid_full <= 1'b0;
      end else if (!accept) begin
        out_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
      end else begin
        skid_full <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      if (skid_full) begin
        checksum <= skid_data;
      end else if (accept) begin
        checksum <= {high_next, low_next};
      end
    end else if (accept) begin
      if (!out_valid) begin
        checksum <= {high_next, low_next};
      end else begin
        skid_data <= {high_next, low_next};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_valid)
    else $error("skid holds a result while the output register is empty");

  a_sums_reduced : assert property (@(posedge clk) disable iff (rst)
    (accept && byte_count != 3'd0) |=>
      (17'(low_sum) < AdlMod && 17'(high_sum) < AdlMod))
    else $error("running sums not reduced below the modulus");

  a_out_drains : assert property (@(posedge clk) disable iff (rst)
    (out_fire && !skid_full && !accept) |=> !out_valid)
    else $error("output still valid after its only result was taken");

  a_skid_fill : assert property (@(posedge clk) disable iff (rst)
    (accept && out_valid && out_stall) |=> skid_full)
    else $error("accepted item lost while the receiver stalled");

endmodule

### rtl/adl32_lane.sv
// ----------------------------------------------------------------------------
// adl32_lane
// One byte lane: masks the byte and weights it by how many high-sum
// additions it still takes part in within the item.
// ----------------------------------------------------------------------------
module adl32_lane #(
  parameter logic [2:0] LaneIdx = 3'd0
) (
  input  logic [adl32_pkg::CntW-1:0]  n_bytes,
  input  adl32_pkg::adl32_byte_t      data,
  output adl32_pkg::adl32_lane_t      lane
);
  import adl32_pkg::*;

  logic             used;
  logic [CntW-1:0]  weight;

  always_comb begin
    used   = (LaneIdx < n_bytes);
    weight = used ? (n_bytes - LaneIdx) : '0;
    lane.byte_val = used ? data : '0;
    // weight is at most four, so the product fits in ten bits
    lane.weighted = 10'(data * weight);
  end

endmodule

### rtl/adl32_merge.sv
// ----------------------------------------------------------------------------
// adl32_merge
// Combines the lane results with the incoming sums and reduces both
// sums modulo 65521.
// ----------------------------------------------------------------------------
module adl32_merge (
  input  adl32_pkg::adl32_lane_t          lanes [adl32_pkg::Lanes],
  input  logic [adl32_pkg::CntW-1:0]      n_bytes,
  input  logic [adl32_pkg::SumW-1:0]      low_in,
  input  logic [adl32_pkg::SumW-1:0]      high_in,
  output logic [adl32_pkg::SumW-1:0]      low_out,
  output logic [adl32_pkg::SumW-1:0]      high_out
);
  import adl32_pkg::*;

  logic [9:0]  byte_tot;
  logic [11:0] wt_tot;
  logic [16:0] low_raw;
  logic [18:0] high_raw;
  logic [16:0] high_fold;

  always_comb begin
    byte_tot = '0;
    wt_tot   = '0;
    for (int i = 0; i < Lanes; i++) begin
      byte_tot = byte_tot + 10'(lanes[i].byte_val);
      wt_tot   = wt_tot + 12'(lanes[i].weighted);
    end

    low_raw  = 17'(low_in) + 17'(byte_tot);
    high_raw = 19'(high_in) + 19'(low_in * n_bytes) + 19'(wt_tot);

    // 2^16 is 15 mod 65521: fold the top bits back in, then one subtract
    high_fold = 17'(high_raw[15:0]) + 17'(high_raw[18:16] * 4'd15);

    if (n_bytes == '0) begin
      low_out  = low_in;
      high_out = high_in;
    end else begin
      low_out  = (low_raw >= AdlMod) ? 16'(low_raw - AdlMod) : low_raw[15:0];
      high_out = (high_fold >= AdlMod) ? 16'(high_fold - AdlMod) : high_fold[15:0];
    end
  end

endmodule
